// ===== rtl/core/sphdp_pkg.sv =====
// ============================================================================
// sphdp_pkg
// Shared types, constants and helpers for the SPH density / pressure block.
// ============================================================================
package sphdp_pkg;

    // Payload geometry
    localparam int OFFSET_WIDTH    = 16;   // signed offset component, Q4.12
    localparam int SUM_WIDTH       = 40;   // density accumulator, Q.16
    localparam int DENSITY_WIDTH   = 32;
    localparam int PRESSURE_WIDTH  = 40;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int IN_TDATA_WIDTH  = ((3 * OFFSET_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_WIDTH = ((DENSITY_WIDTH + PRESSURE_WIDTH + 7) / 8) * 8;

    // Shared multiplier and accumulator
    localparam int MUL_WIDTH  = 32;
    localparam int PROD_WIDTH = 2 * MUL_WIDTH;
    localparam int OPND_WIDTH = 2 * MUL_WIDTH;
    localparam int ACC_WIDTH  = 4 * MUL_WIDTH;

    localparam logic [SUM_WIDTH-1:0]      SUM_MAX      = {SUM_WIDTH{1'b1}};
    localparam logic [DENSITY_WIDTH-1:0]  DENSITY_MAX  = {DENSITY_WIDTH{1'b1}};
    localparam logic [PRESSURE_WIDTH-1:0] PRESSURE_MAX = {PRESSURE_WIDTH{1'b1}};
    localparam logic [OPND_WIDTH-1:0]     ONE_Q16      = 64'h0000_0000_0001_0000;
    localparam logic [32:0]               HUGE_LIMIT   = 33'h0_0000_FFFF;

    // Register reset values
    localparam logic [CFG_DATA_WIDTH-1:0] RST_RADIUS_SQ        = 32'd16777216;
    localparam logic [CFG_DATA_WIDTH-1:0] RST_KERNEL_SCALE     = 32'd65536;
    localparam logic [CFG_DATA_WIDTH-1:0] RST_DENSITY_FLOOR    = 32'd6553;
    localparam logic [CFG_DATA_WIDTH-1:0] RST_INV_REST_DENSITY = 32'd65536;
    localparam logic [CFG_DATA_WIDTH-1:0] RST_STIFFNESS        = 32'd65536;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_RADIUS_SQ        = 3'd0,
        CFG_KERNEL_SCALE     = 3'd1,
        CFG_DENSITY_FLOOR    = 3'd2,
        CFG_INV_REST_DENSITY = 3'd3,
        CFG_STIFFNESS        = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_DATA_WIDTH-1:0] radius_sq;
        logic [CFG_DATA_WIDTH-1:0] kernel_scale;
        logic [CFG_DATA_WIDTH-1:0] density_floor;
        logic [CFG_DATA_WIDTH-1:0] inv_rest_density;
        logic [CFG_DATA_WIDTH-1:0] stiffness;
    } t_cfg;

    // Weight of a partial product in the accumulator
    typedef enum logic [1:0] {
        SH_0  = 2'd0,
        SH_32 = 2'd1,
        SH_64 = 2'd2
    } t_shift;

    // Multiplier operand source
    typedef enum logic [1:0] {
        SRC_OPS   = 2'd0,
        SRC_MAG_X = 2'd1,
        SRC_MAG_Y = 2'd2,
        SRC_MAG_Z = 2'd3
    } t_src;

    // Result capture / operand load operations
    typedef enum logic [3:0] {
        LD_NONE  = 4'd0,
        LD_D     = 4'd1,
        LD_D2    = 4'd2,
        LD_D3    = 4'd3,
        LD_TERM  = 4'd4,
        LD_DENS  = 4'd5,
        LD_RATIO = 4'd6,
        LD_P2    = 4'd7,
        LD_P4    = 4'd8,
        LD_P6    = 4'd9,
        LD_P7    = 4'd10,
        LD_PZERO = 4'd11,
        LD_PRES  = 4'd12,
        LD_OUT   = 4'd13
    } t_ld;

    typedef struct packed {
        logic   load_in;
        logic   mul_valid;
        t_src   mul_src;
        logic   mul_a_hi;
        logic   mul_b_hi;
        t_shift mul_shift;
        logic   mul_clear;
        t_ld    ld;
    } t_cmd;

    typedef struct packed {
        logic skip;   // neighbor adds nothing (huge offset or outside radius)
        logic low;    // ratio^7 at or below 1.0
    } t_status;

    // floor(p >> 16), saturating to all ones past 64 bits
    function automatic logic [OPND_WIDTH-1:0] f_shr16_sat(input logic [ACC_WIDTH-1:0] p);
        logic [OPND_WIDTH-1:0] res;
        res = (|p[ACC_WIDTH-1:80]) ? {OPND_WIDTH{1'b1}} : p[79:16];
        return res;
    endfunction

    // floor(p >> 24), saturating to all ones past 64 bits
    function automatic logic [OPND_WIDTH-1:0] f_shr24_sat(input logic [ACC_WIDTH-1:0] p);
        logic [OPND_WIDTH-1:0] res;
        res = (|p[ACC_WIDTH-1:88]) ? {OPND_WIDTH{1'b1}} : p[87:24];
        return res;
    endfunction

    // Magnitude of a two's complement offset, same width
    function automatic logic [OFFSET_WIDTH-1:0] f_offset_mag(input logic [OFFSET_WIDTH-1:0] v);
        logic [OFFSET_WIDTH-1:0] res;
        res = v[OFFSET_WIDTH-1] ? (~v + 1'b1) : v;
        return res;
    endfunction

endpackage

// ===== rtl/core/sphdp_dp.sv =====
// ============================================================================
// sphdp_dp
// Datapath: shared 32x32 multiplier, 128-bit accumulator, operand and
// density/pressure registers, driven by controller commands.
// ============================================================================
module sphdp_dp (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  sphdp_pkg::t_cfg                         i_cfg,
    input  logic [sphdp_pkg::OFFSET_WIDTH-1:0]      i_offset_x,
    input  logic [sphdp_pkg::OFFSET_WIDTH-1:0]      i_offset_y,
    input  logic [sphdp_pkg::OFFSET_WIDTH-1:0]      i_offset_z,
    input  sphdp_pkg::t_cmd                         i_cmd,
    output sphdp_pkg::t_status                      o_status,
    output logic [sphdp_pkg::DENSITY_WIDTH-1:0]     o_density,
    output logic [sphdp_pkg::PRESSURE_WIDTH-1:0]    o_pressure,
    output logic                                    o_saturated
);

    // Input magnitudes
    logic [sphdp_pkg::OFFSET_WIDTH-1:0]   r_mag_x, r_mag_y, r_mag_z;
    logic [sphdp_pkg::OFFSET_WIDTH-1:0]   w_mag_x, w_mag_y, w_mag_z;
    logic                                 r_huge;
    logic                                 w_huge;

    // Multiplier pipe
    logic [sphdp_pkg::OPND_WIDTH-1:0]     r_opa, r_opb;
    logic [sphdp_pkg::MUL_WIDTH-1:0]      w_mul_a, w_mul_b;
    logic [sphdp_pkg::PROD_WIDTH-1:0]     w_prod;
    logic [sphdp_pkg::PROD_WIDTH-1:0]     r_pp;
    logic                                 r_pp_valid;
    logic                                 r_pp_clear;
    sphdp_pkg::t_shift                    r_pp_shift;
    logic [sphdp_pkg::ACC_WIDTH-1:0]      w_addend;
    logic [sphdp_pkg::ACC_WIDTH-1:0]      w_acc_base;
    logic [sphdp_pkg::ACC_WIDTH-1:0]      r_acc;

    // Derived results
    logic [sphdp_pkg::CFG_DATA_WIDTH-1:0] w_d;
    logic [sphdp_pkg::OPND_WIDTH-1:0]     w_shr16, w_shr24;
    logic [64:0]                          w_tsum;
    logic                                 w_sum_ovf;
    logic                                 w_dens_big;
    logic [sphdp_pkg::DENSITY_WIDTH-1:0]  w_dens_raw, w_dens;
    logic                                 w_pres_big;
    logic [sphdp_pkg::PRESSURE_WIDTH-1:0] w_pres;

    // Particle state
    logic [sphdp_pkg::SUM_WIDTH-1:0]      r_sum;
    logic                                 r_sticky;
    logic [sphdp_pkg::OPND_WIDTH-1:0]     r_ratio, r_p2;
    logic [sphdp_pkg::DENSITY_WIDTH-1:0]  r_dens;
    logic                                 r_sat;
    logic [sphdp_pkg::PRESSURE_WIDTH-1:0] r_pres;
    logic [sphdp_pkg::DENSITY_WIDTH-1:0]  r_out_density;
    logic [sphdp_pkg::PRESSURE_WIDTH-1:0] r_out_pressure;
    logic                                 r_out_sat;

    assign w_mag_x = sphdp_pkg::f_offset_mag(i_offset_x);
    assign w_mag_y = sphdp_pkg::f_offset_mag(i_offset_y);
    assign w_mag_z = sphdp_pkg::f_offset_mag(i_offset_z);
    assign w_huge  = (33'(w_mag_x) > sphdp_pkg::HUGE_LIMIT) |
                     (33'(w_mag_y) > sphdp_pkg::HUGE_LIMIT) |
                     (33'(w_mag_z) > sphdp_pkg::HUGE_LIMIT);

    // Operand select
    always_comb begin
        case (i_cmd.mul_src)
            sphdp_pkg::SRC_MAG_X: begin
                w_mul_a = 32'(r_mag_x);
                w_mul_b = 32'(r_mag_x);
            end
            sphdp_pkg::SRC_MAG_Y: begin
                w_mul_a = 32'(r_mag_y);
                w_mul_b = 32'(r_mag_y);
            end
            sphdp_pkg::SRC_MAG_Z: begin
                w_mul_a = 32'(r_mag_z);
                w_mul_b = 32'(r_mag_z);
            end
            default: begin
                w_mul_a = i_cmd.mul_a_hi ? r_opa[63:32] : r_opa[31:0];
                w_mul_b = i_cmd.mul_b_hi ? r_opb[63:32] : r_opb[31:0];
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // Partial product weight
    always_comb begin
        case (r_pp_shift)
            sphdp_pkg::SH_0:  w_addend = 128'(r_pp);
            sphdp_pkg::SH_32: w_addend = 128'(r_pp) << 32;
            sphdp_pkg::SH_64: w_addend = 128'(r_pp) << 64;
            default:          w_addend = 128'(r_pp);
        endcase
    end

    assign w_acc_base = r_pp_clear ? '0 : r_acc;

    // Results read off the accumulator
    assign w_d     = i_cfg.radius_sq - r_acc[31:0];
    assign w_shr16 = sphdp_pkg::f_shr16_sat(r_acc);
    assign w_shr24 = sphdp_pkg::f_shr24_sat(r_acc);

    assign o_status.skip = r_huge | (r_acc >= 128'(i_cfg.radius_sq));
    assign o_status.low  = (w_shr16 <= sphdp_pkg::ONE_Q16);

    // Saturating density sum
    assign w_tsum    = 65'(r_sum) + 65'(w_shr24);
    assign w_sum_ovf = w_tsum > 65'(sphdp_pkg::SUM_MAX);

    // Density clamp
    assign w_dens_big = r_sticky | (65'(r_sum) > 65'(sphdp_pkg::DENSITY_MAX));
    assign w_dens_raw = w_dens_big ? sphdp_pkg::DENSITY_MAX : r_sum[31:0];
    assign w_dens     = (w_dens_raw < i_cfg.density_floor) ? i_cfg.density_floor
                                                            : w_dens_raw;

    // Pressure: product >> 16 must fit 40 bits
    assign w_pres_big = |r_acc[sphdp_pkg::ACC_WIDTH-1:56];
    assign w_pres     = w_pres_big ? sphdp_pkg::PRESSURE_MAX : r_acc[55:16];

    // Control and particle state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp_valid <= 1'b0;
            r_sum      <= '0;
            r_sticky   <= 1'b0;
        end else begin
            r_pp_valid <= i_cmd.mul_valid;
            case (i_cmd.ld)
                sphdp_pkg::LD_TERM: begin
                    if (w_sum_ovf) begin
                        r_sum    <= sphdp_pkg::SUM_MAX;
                        r_sticky <= 1'b1;
                    end else begin
                        r_sum <= sphdp_pkg::SUM_WIDTH'(w_tsum);
                    end
                end
                sphdp_pkg::LD_OUT: begin
                    r_sum    <= '0;
                    r_sticky <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mag_x <= w_mag_x;
            r_mag_y <= w_mag_y;
            r_mag_z <= w_mag_z;
            r_huge  <= w_huge;
        end

        r_pp       <= w_prod;
        r_pp_clear <= i_cmd.mul_clear;
        r_pp_shift <= i_cmd.mul_shift;
        if (r_pp_valid) begin
            r_acc <= w_acc_base + w_addend;
        end

        case (i_cmd.ld)
            sphdp_pkg::LD_D: begin
                r_opa <= 64'(w_d);
                r_opb <= 64'(w_d);
            end
            sphdp_pkg::LD_D2: begin
                r_opb <= w_shr24;          // d2 = d*d >> 24; opa keeps d
            end
            sphdp_pkg::LD_D3: begin
                r_opa <= 64'(i_cfg.kernel_scale);
                r_opb <= w_shr24;
            end
            sphdp_pkg::LD_DENS: begin
                r_dens <= w_dens;
                r_sat  <= w_dens_big;
                r_opa  <= 64'(w_dens);
                r_opb  <= 64'(i_cfg.inv_rest_density);
            end
            sphdp_pkg::LD_RATIO: begin
                r_ratio <= w_shr16;
                r_opa   <= w_shr16;
                r_opb   <= w_shr16;
            end
            sphdp_pkg::LD_P2: begin
                r_p2  <= w_shr16;
                r_opa <= w_shr16;
                r_opb <= w_shr16;
            end
            sphdp_pkg::LD_P4: begin
                r_opa <= w_shr16;
                r_opb <= r_p2;
            end
            sphdp_pkg::LD_P6: begin
                r_opa <= w_shr16;
                r_opb <= r_ratio;
            end
            sphdp_pkg::LD_P7: begin
                r_opa <= 64'(i_cfg.stiffness);
                r_opb <= w_shr16 - sphdp_pkg::ONE_Q16;
            end
            sphdp_pkg::LD_PZERO: begin
                r_pres <= '0;
            end
            sphdp_pkg::LD_PRES: begin
                r_pres <= w_pres;
                r_sat  <= r_sat | w_pres_big;
            end
            sphdp_pkg::LD_OUT: begin
                r_out_density  <= r_dens;
                r_out_pressure <= r_pres;
                r_out_sat      <= r_sat;
            end
            default: ;
        endcase
    end

    assign o_density   = r_out_density;
    assign o_pressure  = r_out_pressure;
    assign o_saturated = r_out_sat;

endmodule

// ===== rtl/core/sphdp_ctrl.sv =====
// ============================================================================
// sphdp_ctrl
// Controller: sequences partial products, captures and the output handshake.
// ============================================================================
module sphdp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_valid,
    input  logic                i_s_last,
    output logic                o_s_ready,
    input  logic                i_m_ready,
    output logic                o_m_valid,
    input  sphdp_pkg::t_status  i_status,
    output sphdp_pkg::t_cmd     o_cmd
);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_SQ    = 14'b00000000000010,
        S_DSQ   = 14'b00000000000100,
        S_DCUBE = 14'b00000000001000,
        S_TERM  = 14'b00000000010000,
        S_DENS  = 14'b00000000100000,
        S_RATIO = 14'b00000001000000,
        S_P2    = 14'b00000010000000,
        S_P4    = 14'b00000100000000,
        S_P6    = 14'b00001000000000,
        S_P7    = 14'b00010000000000,
        S_PRES  = 14'b00100000000000,
        S_OUT   = 14'b01000000000000
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_step, n_step;
    logic       r_last;
    logic       r_m_valid, n_m_valid;
    logic [2:0] w_count;
    logic       w_issue, w_capture, w_accept, w_out_free;

    // partial products per multiply state
    always_comb begin
        case (r_state)
            S_SQ:    w_count = 3'd3;
            S_DSQ:   w_count = 3'd1;
            S_DCUBE: w_count = 3'd2;
            S_TERM:  w_count = 3'd2;
            S_RATIO: w_count = 3'd1;
            S_P2:    w_count = 3'd4;
            S_P4:    w_count = 3'd4;
            S_P6:    w_count = 3'd4;
            S_P7:    w_count = 3'd4;
            S_PRES:  w_count = 3'd2;
            default: w_count = 3'd0;
        endcase
    end

    assign o_s_ready  = (r_state == S_IDLE);
    assign w_accept   = i_s_valid & o_s_ready;
    assign w_out_free = ~r_m_valid | i_m_ready;
    assign w_issue    = (r_step < w_count);
    // capture once the last partial product has passed r_pp into r_acc
    assign w_capture  = (w_count != 3'd0) && (r_step == w_count + 3'd1);

    always_comb begin
        o_cmd           = '0;
        o_cmd.mul_src   = sphdp_pkg::SRC_OPS;
        o_cmd.mul_shift = sphdp_pkg::SH_0;
        o_cmd.ld        = sphdp_pkg::LD_NONE;
        n_state         = r_state;
        n_step          = r_step;
        n_m_valid       = r_m_valid & ~i_m_ready;

        // partial product issue
        if (w_issue) begin
            o_cmd.mul_valid = 1'b1;
            o_cmd.mul_clear = (r_step == 3'd0);
            if (r_state == S_SQ) begin
                case (r_step)
                    3'd0:    o_cmd.mul_src = sphdp_pkg::SRC_MAG_X;
                    3'd1:    o_cmd.mul_src = sphdp_pkg::SRC_MAG_Y;
                    default: o_cmd.mul_src = sphdp_pkg::SRC_MAG_Z;
                endcase
            end else begin
                case (r_step)
                    3'd1: begin
                        o_cmd.mul_b_hi  = 1'b1;
                        o_cmd.mul_shift = sphdp_pkg::SH_32;
                    end
                    3'd2: begin
                        o_cmd.mul_a_hi  = 1'b1;
                        o_cmd.mul_shift = sphdp_pkg::SH_32;
                    end
                    3'd3: begin
                        o_cmd.mul_a_hi  = 1'b1;
                        o_cmd.mul_b_hi  = 1'b1;
                        o_cmd.mul_shift = sphdp_pkg::SH_64;
                    end
                    default: ;
                endcase
            end
        end

        if (w_capture) begin
            n_step = 3'd0;
        end else if (w_count != 3'd0) begin
            n_step = r_step + 3'd1;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_SQ;
                    n_step        = 3'd0;
                end
            end
            S_SQ: begin
                if (w_capture) begin
                    if (i_status.skip) begin
                        n_state = r_last ? S_DENS : S_IDLE;
                    end else begin
                        o_cmd.ld = sphdp_pkg::LD_D;
                        n_state  = S_DSQ;
                    end
                end
            end
            S_DSQ: begin
                if (w_capture) begin
                    o_cmd.ld = sphdp_pkg::LD_D2;
                    n_state  = S_DCUBE;
                end
            end
            S_DCUBE: begin
                if (w_capture) begin
                    o_cmd.ld = sphdp_pkg::LD_D3;
                    n_state  = S_TERM;
                end
            end
            S_TERM: begin
                if (w_capture) begin
                    o_cmd.ld = sphdp_pkg::LD_TERM;
                    n_state  = r_last ? S_DENS : S_IDLE;
                end
            end
            S_DENS: begin
                o_cmd.ld = sphdp_pkg::LD_DENS;
                n_state  = S_RATIO;
                n_step   = 3'd0;
            end
            S_RATIO: begin
                if (w_capture) begin
                    o_cmd.ld = sphdp_pkg::LD_RATIO;
                    n_state  = S_P2;
                end
            end
            S_P2: begin
                if (w_capture) begin
                    o_cmd.ld = sphdp_pkg::LD_P2;
                    n_state  = S_P4;
                end
            end
            S_P4: begin
                if (w_capture) begin
                    o_cmd.ld = sphdp_pkg::LD_P4;
                    n_state  = S_P6;
                end
            end
            S_P6: begin
                if (w_capture) begin
                    o_cmd.ld = sphdp_pkg::LD_P6;
                    n_state  = S_P7;
                end
            end
            S_P7: begin
                if (w_capture) begin
                    if (i_status.low) begin
                        o_cmd.ld = sphdp_pkg::LD_PZERO;
                        n_state  = S_OUT;
                    end else begin
                        o_cmd.ld = sphdp_pkg::LD_P7;
                        n_state  = S_PRES;
                    end
                end
            end
            S_PRES: begin
                if (w_capture) begin
                    o_cmd.ld = sphdp_pkg::LD_PRES;
                    n_state  = S_OUT;
                end
            end
            S_OUT: begin
                // wait for the output register to drain
                if (w_out_free) begin
                    o_cmd.ld  = sphdp_pkg::LD_OUT;
                    n_m_valid = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_step  = 3'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= 3'd0;
            r_last    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_step    <= n_step;
            r_m_valid <= n_m_valid;
            if (w_accept) begin
                r_last <= i_s_last;
            end
        end
    end

    assign o_m_valid = r_m_valid;

endmodule

// ===== rtl/core/sph_density_pressure.sv =====
// ============================================================================
// sph_density_pressure
// SPH poly6 density accumulation and Tait pressure for one particle at a time.
// ============================================================================
// Usage:
//   Configuration: write registers through i_cfg_valid/i_cfg_index/i_cfg_data
//   while the block is idle; o_cfg_ready is always high. Index 0 radius_sq,
//   1 kernel_scale, 2 density_floor, 3 inv_rest_density, 4 stiffness; other
//   indexes are ignored.
//   Input: one item per neighbor offset (the particle itself at zero offset),
//   s_axis_tlast on the particle's final neighbor. Output: one item per
//   particle carrying density, pressure and the saturation flag.
//   Timing: all multiplies share one 32x32 multiplier feeding a 128-bit
//   accumulator, so items are taken one at a time. A neighbor inside the
//   radius goes through the accept, the sum of squares, then d^2, d^3 and
//   the kernel term; one outside the radius stops after the squares. The
//   last neighbor then adds the density clamp, ratio and the ratio^7 /
//   stiffness products (the stiffness product is skipped when ratio^7 is at
//   or below 1.0), after which the item lands in the output register.
//   Stall: the output register holds its item until m_axis_tready; new
//   neighbors keep being taken meanwhile, and only a second finished
//   particle waits for the register to empty.
//   Reset (i_rst_n low, synchronous): registers return to their defaults,
//   the density sum clears and any pending output item is dropped.
// ============================================================================
module sph_density_pressure (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,

    // Configuration write channel
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [sphdp_pkg::CFG_INDEX_WIDTH-1:0]    i_cfg_index,
    input  logic [sphdp_pkg::CFG_DATA_WIDTH-1:0]     i_cfg_data,

    // Neighbor offsets in
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  logic [sphdp_pkg::IN_TDATA_WIDTH-1:0]     s_axis_tdata,  // offset_x, offset_y, offset_z
    input  logic                                     s_axis_tlast,  // last_neighbor

    // Density / pressure out
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    output logic [sphdp_pkg::OUT_TDATA_WIDTH-1:0]    m_axis_tdata,  // density, pressure
    output logic [0:0]                               m_axis_tuser   // saturated
);

    localparam int OW = sphdp_pkg::OFFSET_WIDTH;

    sphdp_pkg::t_cfg                       r_cfg;
    sphdp_pkg::t_cmd                       w_cmd;
    sphdp_pkg::t_status                    w_status;
    logic [sphdp_pkg::DENSITY_WIDTH-1:0]   w_density;
    logic [sphdp_pkg::PRESSURE_WIDTH-1:0]  w_pressure;
    logic                                  w_saturated;
    logic                                  w_cfg_write;

    // Configuration registers; the sender must write them only while idle, the block does not enforce it
    assign o_cfg_ready = 1'b1;
    assign w_cfg_write = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radius_sq        <= sphdp_pkg::RST_RADIUS_SQ;
            r_cfg.kernel_scale     <= sphdp_pkg::RST_KERNEL_SCALE;
            r_cfg.density_floor    <= sphdp_pkg::RST_DENSITY_FLOOR;
            r_cfg.inv_rest_density <= sphdp_pkg::RST_INV_REST_DENSITY;
            r_cfg.stiffness        <= sphdp_pkg::RST_STIFFNESS;
        end else if (w_cfg_write) begin
            case (sphdp_pkg::t_cfg_idx'(i_cfg_index))
                sphdp_pkg::CFG_RADIUS_SQ:        r_cfg.radius_sq        <= i_cfg_data;
                sphdp_pkg::CFG_KERNEL_SCALE:     r_cfg.kernel_scale     <= i_cfg_data;
                sphdp_pkg::CFG_DENSITY_FLOOR:    r_cfg.density_floor    <= i_cfg_data;
                sphdp_pkg::CFG_INV_REST_DENSITY: r_cfg.inv_rest_density <= i_cfg_data;
                sphdp_pkg::CFG_STIFFNESS:        r_cfg.stiffness        <= i_cfg_data;
                default: ;  // unknown index: ignored
            endcase
        end
    end

    // Sequencer
    sphdp_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_s_last  (s_axis_tlast),
        .o_s_ready (s_axis_tready),
        .i_m_ready (m_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_status  (w_status),
        .o_cmd     (w_cmd)
    );

    // Arithmetic
    sphdp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_offset_x  (s_axis_tdata[OW-1:0]),
        .i_offset_y  (s_axis_tdata[2*OW-1:OW]),
        .i_offset_z  (s_axis_tdata[3*OW-1:2*OW]),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_density   (w_density),
        .o_pressure  (w_pressure),
        .o_saturated (w_saturated)
    );

    // density in the low bits, pressure above it
    assign m_axis_tdata = sphdp_pkg::OUT_TDATA_WIDTH'({w_pressure, w_density});
    assign m_axis_tuser = w_saturated;

endmodule

// ===== dv/sph_density_pressure_tb.sv =====
// ----------------------------------------------------------------------------
// sph_density_pressure_tb
// Self-checking bench for the SPH density / Tait pressure block. Neighbor
// offsets stream in particle by particle. A bit-true predictor in this file
// works out each particle's density, pressure and saturation flag, and the
// output stream is compared field by field against those values. A short
// directed table comes first, then random particles under several register
// settings, with random idling and stalls on both streams.
// ----------------------------------------------------------------------------
module sph_density_pressure_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF        = 6;        // 12 ns period
    localparam int RESET_CYCLES    = 7;
    localparam int CYCLE_LIMIT     = 600000;   // far above the slowest clean run
    localparam int SETTLE_CYCLES   = 80;       // covers a last neighbor and the wrap-up, with margin
    localparam int ITEMS_PER_PHASE = 104;
    localparam int IDLE_PCT        = 38;
    localparam int N_DIRECTED      = 20;

    // Indexes with no register behind them; writes must be dropped
    localparam logic [sphdp_pkg::CFG_INDEX_WIDTH-1:0] CFG_IDX_SPARE_LO = 3'd5;
    localparam logic [sphdp_pkg::CFG_INDEX_WIDTH-1:0] CFG_IDX_SPARE_HI = 3'd7;

    localparam logic [63:0] SUM_LIMIT =
        {{(64-sphdp_pkg::SUM_WIDTH){1'b0}}, sphdp_pkg::SUM_MAX};
    localparam logic [63:0] PRES_LIMIT =
        {{(64-sphdp_pkg::PRESSURE_WIDTH){1'b0}}, sphdp_pkg::PRESSURE_MAX};

    typedef struct packed {
        logic [sphdp_pkg::DENSITY_WIDTH-1:0]  density;
        logic [sphdp_pkg::PRESSURE_WIDTH-1:0] pressure;
        logic                                 saturated;
    } t_particle_out;

    // One row of the directed table. 'typed' rows carry their own expectation.
    typedef struct packed {
        logic [sphdp_pkg::OFFSET_WIDTH-1:0] ox;
        logic [sphdp_pkg::OFFSET_WIDTH-1:0] oy;
        logic [sphdp_pkg::OFFSET_WIDTH-1:0] oz;
        logic                               last;
        logic                               typed;
        t_particle_out                      want;
    } t_dir_row;

    // ------------------------------------------------------------------------
    // DUT hookup; every input known from time zero
    // ------------------------------------------------------------------------
    logic                                  i_clk = 1'b0;
    logic                                  i_rst_n = 1'b0;
    logic                                  i_cfg_valid = 1'b0;
    logic                                  o_cfg_ready;
    logic [sphdp_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index = '0;
    logic [sphdp_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_data = '0;
    logic                                  s_axis_tvalid = 1'b0;
    logic                                  s_axis_tready;
    logic [sphdp_pkg::IN_TDATA_WIDTH-1:0]  s_axis_tdata = '0;   // offset_x, offset_y, offset_z
    logic                                  s_axis_tlast = 1'b0; // last_neighbor
    logic                                  m_axis_tvalid;
    logic                                  m_axis_tready = 1'b0;
    logic [sphdp_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata;        // density, pressure
    logic [0:0]                            m_axis_tuser;        // saturated

    sph_density_pressure DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor state: register shadow, running sum and its sticky overflow
    // ------------------------------------------------------------------------
    sphdp_pkg::t_cfg shadow_cfg;
    logic [63:0]     density_acc;
    bit              acc_overflow;
    t_particle_out   pending_particles[$];  // expected outputs, oldest first

    int  n_errors = 0;
    int  cycle_count = 0;
    bit  calm = 1'b0;                        // no idling on either side
    int  rx_stall = 0;

    // floor((a*b) >> sh); bit 64 flags a result beyond 64 bits (value all ones)
    function automatic logic [64:0] mul_shr(input logic [63:0] a, input logic [63:0] b,
                                            input int unsigned sh);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        if ((prod >> (64 + sh)) != 128'd0)
            return {1'b1, {64{1'b1}}};
        return {1'b0, prod[sh +: 64]};
    endfunction

    function automatic logic [63:0] offset_sq(input logic [sphdp_pkg::OFFSET_WIDTH-1:0] v);
        logic [sphdp_pkg::OFFSET_WIDTH-1:0] m;
        m = v[sphdp_pkg::OFFSET_WIDTH-1] ? (~v + 1'b1) : v;
        return {48'd0, m} * {48'd0, m};
    endfunction

    // Poly6 contribution of one neighbor into the saturating sum.
    // At 16-bit offsets a component never exceeds 0x8000, so the
    // huge-offset rejection cannot fire and is not modeled.
    function automatic void poly6_accumulate(input logic [sphdp_pkg::OFFSET_WIDTH-1:0] x,
                                             input logic [sphdp_pkg::OFFSET_WIDTH-1:0] y,
                                             input logic [sphdp_pkg::OFFSET_WIDTH-1:0] z);
        logic [63:0] r2, d, d2, d3, term;
        logic [64:0] t;
        r2 = offset_sq(x) + offset_sq(y) + offset_sq(z);
        if (r2 >= {32'd0, shadow_cfg.radius_sq})
            return;                          // outside, or exactly on the radius
        d  = {32'd0, shadow_cfg.radius_sq} - r2;
        t  = mul_shr(d, d, 24);   d2 = t[63:0];
        t  = mul_shr(d2, d, 24);  d3 = t[63:0];
        t  = mul_shr({32'd0, shadow_cfg.kernel_scale}, d3, 24);
        term = t[63:0];
        if (term > SUM_LIMIT || term > SUM_LIMIT - density_acc) begin
            density_acc  = SUM_LIMIT;
            acc_overflow = 1'b1;
        end else begin
            density_acc = density_acc + term;
        end
    endfunction

    // Density clamp, ratio^7 and Tait pressure; clears the sum afterwards
    function automatic t_particle_out tait_close_particle();
        t_particle_out res;
        logic [63:0]   dens, ratio, p2, p4, p6, p7, pres;
        logic [64:0]   t;
        bit            sat;
        sat = 1'b0;
        if (acc_overflow || density_acc > 64'hFFFF_FFFF) begin
            dens = 64'hFFFF_FFFF;
            sat  = 1'b1;
        end else begin
            dens = density_acc;
        end
        if (dens < {32'd0, shadow_cfg.density_floor})
            dens = {32'd0, shadow_cfg.density_floor};
        ratio = (dens * {32'd0, shadow_cfg.inv_rest_density}) >> 16;
        t = mul_shr(ratio, ratio, 16); p2 = t[63:0];
        t = mul_shr(p2, p2, 16);       p4 = t[63:0];
        t = mul_shr(p4, p2, 16);       p6 = t[63:0];
        t = mul_shr(p6, ratio, 16);    p7 = t[63:0];
        if (p7 <= sphdp_pkg::ONE_Q16) begin
            pres = 64'd0;
        end else begin
            t = mul_shr({32'd0, shadow_cfg.stiffness}, p7 - sphdp_pkg::ONE_Q16, 16);
            pres = t[63:0];
            if (pres > PRES_LIMIT) begin
                pres = PRES_LIMIT;
                sat  = 1'b1;
            end
        end
        res.density   = dens[sphdp_pkg::DENSITY_WIDTH-1:0];
        res.pressure  = pres[sphdp_pkg::PRESSURE_WIDTH-1:0];
        res.saturated = sat;
        density_acc   = 64'd0;
        acc_overflow  = 1'b0;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Output side: random back-pressure plus field-by-field comparison
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : rx_side
        t_particle_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_particles.size() == 0) begin
                $error("unexpected output item: density %h pressure %h saturated %b",
                       m_axis_tdata[31:0], m_axis_tdata[71:32], m_axis_tuser[0]);
                n_errors++;
            end else begin
                want = pending_particles.pop_front();
                if (m_axis_tdata[31:0] !== want.density) begin
                    $error("density: expected %h, got %h", want.density, m_axis_tdata[31:0]);
                    n_errors++;
                end
                if (m_axis_tdata[71:32] !== want.pressure) begin
                    $error("pressure: expected %h, got %h", want.pressure,
                           m_axis_tdata[71:32]);
                    n_errors++;
                end
                if (m_axis_tuser[0] !== want.saturated) begin
                    $error("saturated: expected %b, got %b", want.saturated, m_axis_tuser[0]);
                    n_errors++;
                end
            end
        end
        // Short random stalls most of the time, now and then a long one so the
        // output register fills while later neighbors are still taken.
        if (calm) begin
            m_axis_tready <= 1'b1;
        end else if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 499) == 0) begin
            rx_stall <= $urandom_range(20, 100);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("sph_density_pressure_tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    // Present one neighbor and hold it until taken. tvalid is only dropped
    // when a gap is inserted, so back-to-back items keep it high.
    task automatic send_neighbor(input logic [sphdp_pkg::OFFSET_WIDTH-1:0] x,
                                 input logic [sphdp_pkg::OFFSET_WIDTH-1:0] y,
                                 input logic [sphdp_pkg::OFFSET_WIDTH-1:0] z,
                                 input bit last);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < IDLE_PCT)
            gap = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 60 : 3);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {z, y, x};
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic feed_neighbor(input logic [sphdp_pkg::OFFSET_WIDTH-1:0] x,
                                 input logic [sphdp_pkg::OFFSET_WIDTH-1:0] y,
                                 input logic [sphdp_pkg::OFFSET_WIDTH-1:0] z,
                                 input bit last);
        t_particle_out res;
        send_neighbor(x, y, z, last);
        poly6_accumulate(x, y, z);
        if (last) begin
            res = tait_close_particle();
            pending_particles.insert(pending_particles.size(), res);
        end
    endtask

    // Stop sending, let every expected particle come out, then let the
    // block settle so a register write lands on an idle datapath.
    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        while (pending_particles.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Leaves i_cfg_valid high; the caller drops it after the last write
    task automatic cfg_write(input logic [sphdp_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             input logic [sphdp_pkg::CFG_DATA_WIDTH-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            sphdp_pkg::CFG_RADIUS_SQ:        shadow_cfg.radius_sq        = val;
            sphdp_pkg::CFG_KERNEL_SCALE:     shadow_cfg.kernel_scale     = val;
            sphdp_pkg::CFG_DENSITY_FLOOR:    shadow_cfg.density_floor    = val;
            sphdp_pkg::CFG_INV_REST_DENSITY: shadow_cfg.inv_rest_density = val;
            sphdp_pkg::CFG_STIFFNESS:        shadow_cfg.stiffness        = val;
            default: ;            // no register there
        endcase
    endtask

    task automatic program_cfg(input sphdp_pkg::t_cfg c, input bit spare);
        cfg_write(sphdp_pkg::CFG_RADIUS_SQ,        c.radius_sq);
        cfg_write(sphdp_pkg::CFG_KERNEL_SCALE,     c.kernel_scale);
        cfg_write(sphdp_pkg::CFG_DENSITY_FLOOR,    c.density_floor);
        cfg_write(sphdp_pkg::CFG_INV_REST_DENSITY, c.inv_rest_density);
        cfg_write(sphdp_pkg::CFG_STIFFNESS,        c.stiffness);
        if (spare) begin
            // These must not alias onto any real register
            cfg_write(CFG_IDX_SPARE_LO, $urandom);
            cfg_write(CFG_IDX_SPARE_HI, $urandom);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // One offset component. Mostly well inside the radius (reach is the
    // radius in Q4.12), some near the edge, the rest any 16-bit value.
    function automatic logic [sphdp_pkg::OFFSET_WIDTH-1:0] pick_component(input int reach);
        int mag;
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: mag = $urandom_range(0, reach * 3 / 5);
            7:                   mag = $urandom_range(reach * 3 / 5, reach);
            default:             return sphdp_pkg::OFFSET_WIDTH'($urandom_range(0, 16'hFFFF));
        endcase
        if (mag > 32'h7FFF)
            mag = 32'h7FFF;
        v = $urandom_range(0, 1) ? -mag : mag;
        return v[sphdp_pkg::OFFSET_WIDTH-1:0];
    endfunction

    // Program a setting, then stream random particles under it
    task automatic run_phase(input sphdp_pkg::t_cfg c, input int reach, input bit spare,
                             input bit quiet);
        int fed;
        int nb;
        int k;
        logic [sphdp_pkg::OFFSET_WIDTH-1:0] x, y, z;
        drain_pipeline();
        program_cfg(c, spare);
        calm <= quiet;
        fed = 0;
        while (fed < ITEMS_PER_PHASE) begin
            // Mostly small neighborhoods, occasionally a crowded one
            nb = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 8);
            for (k = 0; k < nb; k++) begin
                if (k == 0 && $urandom_range(0, 9) < 6) begin
                    x = '0; y = '0; z = '0;      // the particle itself
                end else begin
                    x = pick_component(reach);
                    y = pick_component(reach);
                    z = pick_component(reach);
                end
                feed_neighbor(x, y, z, k == nb - 1);
                fed++;
            end
        end
        calm <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Directed table, run under the reset register values (radius 1.0,
    // kernel scale 1.0, floor 6553, inverse rest density 1.0, stiffness 1.0).
    // A lone zero offset adds exactly 1.0; ratio^7 of 2.0 is 128.0 and of
    // 4.0 is 16384.0, so those pressures can be written down directly.
    // ------------------------------------------------------------------------
    t_dir_row dir_rows [0:N_DIRECTED-1];

    initial begin
        dir_rows = '{
            // self alone: density 1.0, ratio^7 = 1.0 so no pressure
            '{16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, '{32'h0001_0000, 40'h0, 1'b0}},
            // exactly on the radius: nothing added, density floored
            '{16'h1000, 16'h0000, 16'h0000, 1'b1, 1'b1, '{32'h0000_1999, 40'h0, 1'b0}},
            // field extremes, far outside
            '{16'h8000, 16'h7FFF, 16'h8000, 1'b1, 1'b1, '{32'h0000_1999, 40'h0, 1'b0}},
            '{16'h7FFF, 16'h8000, 16'h7FFF, 1'b1, 1'b1, '{32'h0000_1999, 40'h0, 1'b0}},
            // two at zero offset: density 2.0, pressure 127.0
            '{16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, '0},
            '{16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, '{32'h0002_0000, 40'h7F_0000, 1'b0}},
            // negative boundary, then just inside
            '{16'h0000, 16'hF000, 16'h0000, 1'b0, 1'b0, '0},
            '{16'h0000, 16'h0000, 16'h0FFF, 1'b1, 1'b0, '0},
            // partial kernel terms
            '{16'h0800, 16'h0800, 16'h0800, 1'b0, 1'b0, '0},
            '{16'hF800, 16'h0000, 16'h0000, 1'b0, 1'b0, '0},
            '{16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, '0},
            '{16'h0400, 16'hFC00, 16'h0400, 1'b1, 1'b0, '0},
            // four at zero offset: density 4.0, pressure 16383.0
            '{16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, '0},
            '{16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, '0},
            '{16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, '0},
            '{16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, '{32'h0004_0000, 40'h3F_FF00_00, 1'b0}},
            // smallest nonzero offsets
            '{16'h0001, 16'hFFFF, 16'h0001, 1'b1, 1'b0, '0},
            // outside neighbors contribute nothing to the particle they belong to
            '{16'h7FFF, 16'h0000, 16'h0000, 1'b0, 1'b0, '0},
            '{16'h0000, 16'h8000, 16'h0000, 1'b0, 1'b0, '0},
            '{16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, '{32'h0001_0000, 40'h0, 1'b0}}
        };
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        t_particle_out   res;
        sphdp_pkg::t_cfg c;
        int              rad;
        int              i;

        shadow_cfg.radius_sq        = sphdp_pkg::RST_RADIUS_SQ;
        shadow_cfg.kernel_scale     = sphdp_pkg::RST_KERNEL_SCALE;
        shadow_cfg.density_floor    = sphdp_pkg::RST_DENSITY_FLOOR;
        shadow_cfg.inv_rest_density = sphdp_pkg::RST_INV_REST_DENSITY;
        shadow_cfg.stiffness        = sphdp_pkg::RST_STIFFNESS;
        density_acc  = 64'd0;
        acc_overflow = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows, checked against reset register values
        for (i = 0; i < N_DIRECTED; i++) begin
            send_neighbor(dir_rows[i].ox, dir_rows[i].oy, dir_rows[i].oz, dir_rows[i].last);
            poly6_accumulate(dir_rows[i].ox, dir_rows[i].oy, dir_rows[i].oz);
            if (dir_rows[i].last) begin
                res = tait_close_particle();
                if (dir_rows[i].typed)
                    res = dir_rows[i].want;
                pending_particles.insert(pending_particles.size(), res);
            end
        end

        // Moderate water-like setting; spare indexes poked after the real ones
        c = '{32'h0100_0000, 32'h0000_8000, 32'h0000_1999, 32'h0000_5555, 32'h000A_0000};
        run_phase(c, 16'h1000, 1'b1, 1'b0);

        // Everything zero: nothing inside, density and pressure zero
        c = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
        run_phase(c, 16'h0400, 1'b0, 1'b0);

        // Everything all ones: sum overflow, density and pressure saturate
        c = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        run_phase(c, 16'hFFFF, 1'b1, 1'b0);

        // Wide radius, small kernel scale; both streams run without gaps
        c = '{32'h1000_0000, 32'h0000_0100, 32'h0001_0000, 32'h0000_2000, 32'h0064_0000};
        run_phase(c, 16'h4000, 1'b0, 1'b1);

        // Random settings with magnitudes spread over the whole range
        repeat (4) begin
            rad = $urandom_range(16'h0100, 16'hFFFF);
            c.radius_sq        = rad * rad + $urandom_range(0, rad);
            c.kernel_scale     = $urandom >> $urandom_range(0, 31);
            c.density_floor    = $urandom >> $urandom_range(8, 31);
            c.inv_rest_density = $urandom >> $urandom_range(0, 31);
            c.stiffness        = $urandom >> $urandom_range(0, 31);
            run_phase(c, rad, 1'b0, 1'b0);
        end

        // Wind down: everything out, then a quiet spell for stray outputs
        s_axis_tvalid <= 1'b0;
        while (pending_particles.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_particles.size() != 0) begin
            $error("%0d expected particles never came out", pending_particles.size());
            n_errors++;
        end
        if (n_errors == 0) begin
            $display("sph_density_pressure_tb: done, clean");
        end else begin
            $display("sph_density_pressure_tb: done, errors");
        end
        $finish;
    end

endmodule
